### rtl/core/byte_stream_tokenizer_unit_assert.svh
// Assertion macros shared by the tokenizer RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef BYTE_STREAM_TOKENIZER_UNIT_ASSERT_SVH
`define BYTE_STREAM_TOKENIZER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define BSTU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tokenizer assertion failed");

// Next-cycle implication, disabled while reset is held.
`define BSTU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tokenizer assertion failed");

`endif

### rtl/core/bstu_pkg.sv
// Package for the byte stream tokenizer: token kinds, scan modes, result types,
// the keyword table and the punctuation decoder. Depends on nothing.
`timescale 1ns / 1ps

package bstu_pkg;

    // Keyword buffer depth default and keyword table shape.
    localparam int unsigned KEYWORD_CHARS_DEF = 9;
    localparam int unsigned KW_COUNT          = 12;
    localparam int unsigned KW_MAX            = 9;

    // Scan modes.
    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_WORD = 3'd1;
    localparam logic [2:0] MODE_NUM  = 3'd2;
    localparam logic [2:0] MODE_STR  = 3'd3;
    localparam logic [2:0] MODE_ESC  = 3'd4;
    localparam logic [2:0] MODE_GT   = 3'd5;

    // Token kinds.
    localparam logic [5:0] K_ENTITY    = 6'd0;
    localparam logic [5:0] K_COMPONENT = 6'd1;
    localparam logic [5:0] K_SYSTEM    = 6'd2;
    localparam logic [5:0] K_IO        = 6'd3;
    localparam logic [5:0] K_THREADED  = 6'd4;
    localparam logic [5:0] K_PIPELINE  = 6'd6;
    localparam logic [5:0] K_READ      = 6'd7;
    localparam logic [5:0] K_WRITE     = 6'd8;
    localparam logic [5:0] K_EDIT      = 6'd9;
    localparam logic [5:0] K_LPAREN    = 6'd10;
    localparam logic [5:0] K_RPAREN    = 6'd11;
    localparam logic [5:0] K_LBRACE    = 6'd12;
    localparam logic [5:0] K_RBRACE    = 6'd13;
    localparam logic [5:0] K_LBRACKET  = 6'd14;
    localparam logic [5:0] K_RBRACKET  = 6'd15;
    localparam logic [5:0] K_COMMA     = 6'd16;
    localparam logic [5:0] K_SEMI      = 6'd17;
    localparam logic [5:0] K_COLON     = 6'd18;
    localparam logic [5:0] K_DOT       = 6'd19;
    localparam logic [5:0] K_ARROW     = 6'd20;
    localparam logic [5:0] K_PIPE      = 6'd21;
    localparam logic [5:0] K_IF        = 6'd22;
    localparam logic [5:0] K_ELSE      = 6'd23;
    localparam logic [5:0] K_NUMBER    = 6'd24;
    localparam logic [5:0] K_STRING    = 6'd25;
    localparam logic [5:0] K_ASSIGN    = 6'd26;
    localparam logic [5:0] K_PLUS      = 6'd27;
    localparam logic [5:0] K_MINUS     = 6'd28;
    localparam logic [5:0] K_STAR      = 6'd29;
    localparam logic [5:0] K_SLASH     = 6'd30;
    localparam logic [5:0] K_AMP       = 6'd31;
    localparam logic [5:0] K_LET       = 6'd32;
    localparam logic [5:0] K_END       = 6'd33;
    localparam logic [5:0] K_IDENT     = 6'd34;
    localparam logic [5:0] K_ERROR     = 6'd35;

    // Characters with a special role in the scanner.
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // Keyword spellings, right-aligned in 72 bits, with lengths and kinds.
    localparam logic [8*KW_MAX-1:0] KW_SPELL [KW_COUNT] = '{
        "Entity", "Component", "System", "Threaded", "Pipeline", "read",
        "write", "edit", "IO", "if", "else", "let"
    };
    localparam int unsigned KW_LEN [KW_COUNT] = '{6, 9, 6, 8, 8, 4, 5, 4, 2, 2, 4, 3};
    localparam logic [5:0] KW_KIND [KW_COUNT] = '{
        K_ENTITY, K_COMPONENT, K_SYSTEM, K_THREADED, K_PIPELINE, K_READ,
        K_WRITE, K_EDIT, K_IO, K_IF, K_ELSE, K_LET
    };

    // One result beat.
    typedef struct packed {
        logic       tend;
        logic [5:0] kind;
        logic [7:0] byt;
    } t_res;

    // Everything one input byte does: results, next scan state, buffer write.
    typedef struct packed {
        logic [1:0]       cnt;
        t_res [2:0]       res;
        logic [2:0]       mode;
        logic [3:0]       len;
        logic             wr_en;
        logic [3:0]       wr_pos;
        logic             done;
    } t_scan;

    // Kind of a finished word: a keyword kind, or identifier.
    function automatic logic [5:0] kw_kind(input logic [KW_MAX-1:0][7:0] wb,
                                           input logic [3:0] len);
        logic [5:0]          kind;
        logic                hit;
        logic [8*KW_MAX-1:0] sp;
        kind = K_IDENT;
        // Walk backwards so the first table entry that matches wins.
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            sp  = KW_SPELL[k] << (8 * (KW_MAX - KW_LEN[k]));
            hit = (len == 4'(KW_LEN[k]));
            for (int i = 0; i < KW_MAX; i++) begin
                if (i < KW_LEN[k] && wb[i] != sp[8*KW_MAX-1-8*i -: 8]) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                kind = KW_KIND[k];
            end
        end
        return kind;
    endfunction

    // Single-character tokens; anything else is an error.
    function automatic logic [5:0] punct_kind(input logic [7:0] c);
        logic [5:0] kind;
        case (c)
            "(": kind = K_LPAREN;
            ")": kind = K_RPAREN;
            "{": kind = K_LBRACE;
            "}": kind = K_RBRACE;
            "[": kind = K_LBRACKET;
            "]": kind = K_RBRACKET;
            ",": kind = K_COMMA;
            ";": kind = K_SEMI;
            ":": kind = K_COLON;
            ".": kind = K_DOT;
            "|": kind = K_PIPE;
            "=": kind = K_ASSIGN;
            "+": kind = K_PLUS;
            "-": kind = K_MINUS;
            "*": kind = K_STAR;
            "/": kind = K_SLASH;
            "&": kind = K_AMP;
            default: kind = K_ERROR;
        endcase
        return kind;
    endfunction

endpackage

### rtl/core/bstu_scan.sv
// Combinational scanner step: classifies one byte against the current scan mode
// and produces up to three results and the next state. Depends on bstu_pkg.
`timescale 1ns / 1ps

module bstu_scan (
    input  logic [2:0]                        i_mode,
    input  logic [3:0]                        i_len,
    input  logic [bstu_pkg::KW_MAX-1:0][7:0]  i_word,
    input  logic [7:0]                        i_byte,
    input  logic                              i_fin,
    output bstu_pkg::t_scan                   o_scan
);

    logic            is_alpha;
    logic            is_digit;
    logic            is_space;
    logic [5:0]      word_kind;
    logic [3:0]      len_inc;

    // Byte that lands in idle.
    logic            idle_has;
    bstu_pkg::t_res  idle_res;
    logic [2:0]      idle_mode;
    logic            idle_start;
    logic            idle_done;

    bstu_pkg::t_scan s;

    // Character classes and the keyword lookup of the word so far.
    always_comb begin
        is_alpha  = (i_byte inside {["A":"Z"], ["a":"z"]});
        is_digit  = (i_byte inside {["0":"9"]});
        is_space  = (i_byte inside {" ", 8'h09, 8'h0D, bstu_pkg::CH_LF});
        word_kind = bstu_pkg::kw_kind(i_word, i_len);
        len_inc   = (i_len == 4'hF) ? 4'hF : i_len + 4'd1;
    end

    // Handling of a byte seen between tokens.
    always_comb begin
        idle_has   = 1'b0;
        idle_res   = '{tend: 1'b1, kind: bstu_pkg::K_END, byt: bstu_pkg::CH_NUL};
        idle_mode  = bstu_pkg::MODE_IDLE;
        idle_start = 1'b0;
        idle_done  = 1'b0;
        if (i_fin) begin
            idle_has  = 1'b1;
            idle_done = 1'b1;
        end else if (is_space) begin
            idle_has = 1'b0;
        end else if (i_byte == bstu_pkg::CH_QUOTE) begin
            idle_mode = bstu_pkg::MODE_STR;
        end else if (i_byte == bstu_pkg::CH_GT) begin
            idle_mode = bstu_pkg::MODE_GT;
        end else if (is_alpha || i_byte == "_") begin
            idle_has   = 1'b1;
            idle_mode  = bstu_pkg::MODE_WORD;
            idle_start = 1'b1;
            idle_res   = '{tend: 1'b0, kind: bstu_pkg::K_IDENT, byt: i_byte};
        end else if (is_digit) begin
            idle_has  = 1'b1;
            idle_mode = bstu_pkg::MODE_NUM;
            idle_res  = '{tend: 1'b0, kind: bstu_pkg::K_NUMBER, byt: i_byte};
        end else begin
            idle_has = 1'b1;
            idle_res = '{tend: 1'b1, kind: bstu_pkg::punct_kind(i_byte), byt: i_byte};
        end
    end

    // Mode dispatch; a token close, if any, goes ahead of the idle handling.
    always_comb begin
        s        = '0;
        s.mode   = i_mode;
        s.len    = i_len;
        s.wr_pos = i_len;
        case (i_mode)
            bstu_pkg::MODE_WORD: begin
                if (!i_fin && (is_alpha || is_digit || i_byte == "_")) begin
                    s.cnt    = 2'd1;
                    s.res[0] = '{tend: 1'b0, kind: bstu_pkg::K_IDENT, byt: i_byte};
                    s.wr_en  = 1'b1;
                    s.len    = len_inc;
                end else begin
                    s.res[0] = '{tend: 1'b1, kind: word_kind, byt: bstu_pkg::CH_NUL};
                    s.res[1] = idle_res;
                    s.cnt    = idle_has ? 2'd2 : 2'd1;
                    s.mode   = idle_mode;
                    s.done   = idle_done;
                end
            end
            bstu_pkg::MODE_NUM: begin
                if (!i_fin && (is_digit || i_byte == ".")) begin
                    s.cnt    = 2'd1;
                    s.res[0] = '{tend: 1'b0, kind: bstu_pkg::K_NUMBER, byt: i_byte};
                end else begin
                    s.res[0] = '{tend: 1'b1, kind: bstu_pkg::K_NUMBER,
                                 byt: bstu_pkg::CH_NUL};
                    s.res[1] = idle_res;
                    s.cnt    = idle_has ? 2'd2 : 2'd1;
                    s.mode   = idle_mode;
                    s.done   = idle_done;
                end
            end
            bstu_pkg::MODE_STR: begin
                if (i_fin) begin
                    s.res[0] = '{tend: 1'b1, kind: bstu_pkg::K_STRING,
                                 byt: bstu_pkg::CH_NUL};
                    s.res[1] = idle_res;
                    s.cnt    = 2'd2;
                    s.mode   = bstu_pkg::MODE_IDLE;
                    s.done   = 1'b1;
                end else if (i_byte == bstu_pkg::CH_QUOTE) begin
                    s.res[0] = '{tend: 1'b1, kind: bstu_pkg::K_STRING,
                                 byt: bstu_pkg::CH_NUL};
                    s.cnt    = 2'd1;
                    s.mode   = bstu_pkg::MODE_IDLE;
                end else if (i_byte == bstu_pkg::CH_BSLASH) begin
                    s.mode = bstu_pkg::MODE_ESC;
                end else begin
                    s.res[0] = '{tend: 1'b0, kind: bstu_pkg::K_STRING, byt: i_byte};
                    s.cnt    = 2'd1;
                end
            end
            bstu_pkg::MODE_ESC: begin
                // A kept backslash comes first, unless a quote, backslash or n replaces it.
                s.res[0] = '{tend: 1'b0, kind: bstu_pkg::K_STRING,
                             byt: bstu_pkg::CH_BSLASH};
                s.mode   = bstu_pkg::MODE_STR;
                if (i_fin) begin
                    s.res[1] = '{tend: 1'b1, kind: bstu_pkg::K_STRING,
                                 byt: bstu_pkg::CH_NUL};
                    s.res[2] = idle_res;
                    s.cnt    = 2'd3;
                    s.mode   = bstu_pkg::MODE_IDLE;
                    s.done   = 1'b1;
                end else if (i_byte == bstu_pkg::CH_QUOTE || i_byte == bstu_pkg::CH_BSLASH) begin
                    s.res[0].byt = i_byte;
                    s.cnt        = 2'd1;
                end else if (i_byte == bstu_pkg::CH_N) begin
                    s.res[0].byt = bstu_pkg::CH_LF;
                    s.cnt        = 2'd1;
                end else begin
                    s.res[1] = '{tend: 1'b0, kind: bstu_pkg::K_STRING, byt: i_byte};
                    s.cnt    = 2'd2;
                end
            end
            bstu_pkg::MODE_GT: begin
                if (!i_fin && i_byte == bstu_pkg::CH_GT) begin
                    s.res[0] = '{tend: 1'b1, kind: bstu_pkg::K_ARROW,
                                 byt: bstu_pkg::CH_GT};
                    s.cnt    = 2'd1;
                    s.mode   = bstu_pkg::MODE_IDLE;
                end else begin
                    s.res[0] = '{tend: 1'b1, kind: bstu_pkg::K_ERROR,
                                 byt: bstu_pkg::CH_GT};
                    s.res[1] = idle_res;
                    s.cnt    = idle_has ? 2'd2 : 2'd1;
                    s.mode   = idle_mode;
                    s.done   = idle_done;
                    if (idle_start) begin
                        s.wr_en  = 1'b1;
                        s.wr_pos = 4'd0;
                        s.len    = 4'd1;
                    end
                end
            end
            default: begin
                // Idle, and the unused codes that behave as idle.
                s.res[0] = idle_res;
                s.cnt    = idle_has ? 2'd1 : 2'd0;
                s.mode   = idle_mode;
                s.done   = idle_done;
                if (idle_start) begin
                    s.wr_en  = 1'b1;
                    s.wr_pos = 4'd0;
                    s.len    = 4'd1;
                end
            end
        endcase
        // A word or number that closes into another word start restarts the buffer.
        if ((i_mode == bstu_pkg::MODE_WORD || i_mode == bstu_pkg::MODE_NUM)
            && s.res[0].tend && idle_start) begin
            s.wr_en  = 1'b1;
            s.wr_pos = 4'd0;
            s.len    = 4'd1;
        end
    end

    assign o_scan = s;

endmodule

### rtl/core/bstu_outq.sv
// Four-entry result queue between the scanner and the output channel.
// Takes up to three results per beat, drains one per cycle while i_ready is high. Depends on bstu_pkg.
`timescale 1ns / 1ps

`include "byte_stream_tokenizer_unit_assert.svh"

module bstu_outq (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [1:0]             i_push_cnt,
    input  bstu_pkg::t_res [2:0]   i_push_res,
    output logic                   o_space,
    input  logic                   i_ready,
    output logic                   o_valid,
    output bstu_pkg::t_res         o_head,
    output logic                   o_head_last
);

    typedef struct packed {
        bstu_pkg::t_res res;
        logic           last;
    } t_qent;

    t_qent       r_q [4];
    t_qent       n_q [4];
    logic [2:0]  r_cnt;
    logic [2:0]  n_cnt;
    logic        pop;
    logic [2:0]  base;

    assign o_valid     = (r_cnt != 3'd0);
    assign o_head      = r_q[0].res;
    assign o_head_last = r_q[0].last;
    assign pop         = o_valid & i_ready;
    assign base        = r_cnt - {2'b00, pop};
    // Room for a full three-result beat after this cycle's drain.
    assign o_space     = (base <= 3'd1);

    // Shift out the head on a pop, then append the new results behind the rest.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_q[j] = pop ? r_q[j + 1] : r_q[j];
        end
        n_q[3] = r_q[3];
        for (int j = 0; j < 4; j++) begin
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < i_push_cnt && 3'(base + 3'(i)) == 3'(j)) begin
                    n_q[j].res  = i_push_res[i];
                    n_q[j].last = (2'(i) == i_push_cnt - 2'd1);
                end
            end
        end
        n_cnt = base + {1'b0, i_push_cnt};
    end

    // Entries carry no reset; the count does.
    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    `BSTU_ASSERT_IMPL(a_cnt_max, i_clk, i_rst_n, 1'b1, r_cnt <= 3'd4)
    `BSTU_ASSERT_IMPL(a_push_fits, i_clk, i_rst_n, i_push_cnt != 2'd0, o_space)
    `BSTU_ASSERT_IMPL(a_tail_last, i_clk, i_rst_n, r_cnt != 3'd0,
                      r_q[r_cnt[1:0] - 2'd1].last)

endmodule

### rtl/core/byte_stream_tokenizer_unit.sv
// Top level of the byte stream tokenizer: scan state, keyword buffer and the
// handshakes. Depends on bstu_pkg, bstu_scan, bstu_outq and the assertion header.
`timescale 1ns / 1ps

// The tokenizer takes one text byte per input beat and delivers token results
// one per output beat; each result is a payload byte (token_end low) or a
// token close (token_end high) with its kind, and last_of_run marks the final
// result caused by an input byte. A byte is classified, matched against the
// keyword table and turned into its results in the cycle it is accepted; they
// enter the result queue register behind any still waiting. Throughput is one
// byte per cycle while each byte makes at most one result and the output does
// not stall; a byte that makes two or three results (a word or number closed
// by punctuation, a pending escape at the end of text) can slow the input,
// because the four-entry result queue drains one result per cycle and the
// input is held off until room for three results is certain. After the
// end-of-text token, input beats are taken but give nothing until reset.

`include "byte_stream_tokenizer_unit_assert.svh"

module byte_stream_tokenizer_unit #(
    parameter int unsigned KEYWORD_CHARS = bstu_pkg::KEYWORD_CHARS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_text,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_token_end,
    output logic [5:0] o_token_kind,
    output logic [7:0] o_byte_out,
    output logic       o_last_of_run
);

    localparam int unsigned WIDX = $clog2(KEYWORD_CHARS);

    logic [2:0]                        r_mode;
    logic [3:0]                        r_len;
    logic                              r_done;
    logic [7:0]                        r_word [KEYWORD_CHARS];
    logic [bstu_pkg::KW_MAX-1:0][7:0]  word_head;
    logic                              fin;
    logic                              accept;
    logic                              step;
    logic [1:0]                        push_cnt;
    bstu_pkg::t_scan                   scan;
    bstu_pkg::t_res                    head;

    assign fin    = i_end_of_text | (i_in_byte == bstu_pkg::CH_NUL);
    assign accept = i_in_valid & o_in_ready;
    assign step   = accept & ~r_done;

    // The keyword compare looks at the first KW_MAX buffered bytes.
    always_comb begin
        for (int i = 0; i < bstu_pkg::KW_MAX; i++) begin
            word_head[i] = r_word[i];
        end
    end

    bstu_scan u_scan (
        .i_mode (r_mode),
        .i_len  (r_len),
        .i_word (word_head),
        .i_byte (i_in_byte),
        .i_fin  (fin),
        .o_scan (scan)
    );

    assign push_cnt = step ? scan.cnt : 2'd0;

    bstu_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_cnt  (push_cnt),
        .i_push_res  (scan.res),
        .o_space     (o_in_ready),
        .i_ready     (i_out_ready),
        .o_valid     (o_out_valid),
        .o_head      (head),
        .o_head_last (o_last_of_run)
    );

    assign o_token_end  = head.tend;
    assign o_token_kind = head.kind;
    assign o_byte_out   = head.byt;

    // Scan state advances on every accepted beat until the text is done.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= bstu_pkg::MODE_IDLE;
            r_len  <= 4'd0;
            r_done <= 1'b0;
        end else if (step) begin
            r_mode <= scan.mode;
            r_len  <= scan.len;
            r_done <= scan.done;
        end
    end

    // Keyword buffer keeps only the first KEYWORD_CHARS bytes of a word.
    always_ff @(posedge i_clk) begin
        if (step && scan.wr_en && ({1'b0, scan.wr_pos} < 5'(KEYWORD_CHARS))) begin
            r_word[scan.wr_pos[WIDX-1:0]] <= i_in_byte;
        end
    end

    `BSTU_ASSERT_IMPL(a_done_sticky, i_clk, i_rst_n, $past(r_done), r_done)
    `BSTU_ASSERT_NEXT(a_fin_sets_done, i_clk, i_rst_n, step && fin, r_done)
    `BSTU_ASSERT_NEXT(a_fin_gives_token, i_clk, i_rst_n, step && fin, o_out_valid)

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for byte_stream_tokenizer_unit: a directed table, then random
// source text, checked beat by beat against a token predictor kept in this file.
// Depends on bstu_pkg and the tokenizer RTL.
`timescale 1ns / 1ps

module testbench;
    import bstu_pkg::*;

    localparam int KW_BUF     = KEYWORD_CHARS_DEF;
    localparam int TEXT_BEATS = 420;
    localparam int IDLE_LIMIT = 500;
    localparam int DRAIN_WAIT = 30;

    // One token beat as it leaves the block.
    typedef struct packed {
        logic       tend;
        logic [5:0] kind;
        logic [7:0] byt;
        logic       last;
    } t_token_beat;

    // One directed row; typed rows carry their expected token end, if any, inline.
    typedef struct packed {
        logic [7:0] ch;
        bit         typed;
        bit         has_res;
        logic [5:0] kind;
        logic [7:0] byt;
    } t_dir_row;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       in_eot;
    logic       out_valid;
    logic       out_ready;
    logic       tok_end;
    logic [5:0] tok_kind;
    logic [7:0] tok_byte;
    logic       tok_last;

    byte_stream_tokenizer_unit #(
        .KEYWORD_CHARS(KW_BUF)
    ) i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_in_byte    (in_byte),
        .i_end_of_text(in_eot),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_token_end  (tok_end),
        .o_token_kind (tok_kind),
        .o_byte_out   (tok_byte),
        .o_last_of_run(tok_last)
    );

    // Keyword spellings and the token kind each one closes with.
    string      kw_text [12] = '{"Entity", "Component", "System", "Threaded", "Pipeline",
                                 "read", "write", "edit", "IO", "if", "else", "let"};
    logic [5:0] kw_tag  [12] = '{K_ENTITY, K_COMPONENT, K_SYSTEM, K_THREADED, K_PIPELINE,
                                 K_READ, K_WRITE, K_EDIT, K_IO, K_IF, K_ELSE, K_LET};

    // Single-character tokens, in the same order as their kinds below.
    string      punct_chars = "(){}[],;:.|=+-*/&";
    logic [5:0] punct_tags [17] = '{K_LPAREN, K_RPAREN, K_LBRACE, K_RBRACE, K_LBRACKET,
                                    K_RBRACKET, K_COMMA, K_SEMI, K_COLON, K_DOT, K_PIPE,
                                    K_ASSIGN, K_PLUS, K_MINUS, K_STAR, K_SLASH, K_AMP};
    string      blanks = " \t\r\n";

    // Directed text: extremes, every scanner mode and the escape rules.
    t_dir_row dir_tbl [26] = '{
        '{8'h20,     1'b1, 1'b0, K_IDENT,  8'h00},
        '{"(",       1'b1, 1'b1, K_LPAREN, "("},
        '{")",       1'b1, 1'b1, K_RPAREN, ")"},
        '{8'hFF,     1'b1, 1'b1, K_ERROR,  8'hFF},
        '{8'h01,     1'b1, 1'b1, K_ERROR,  8'h01},
        '{"I",       1'b0, 1'b0, K_IDENT,  8'h00},
        '{"O",       1'b0, 1'b0, K_IDENT,  8'h00},
        '{";",       1'b0, 1'b0, K_IDENT,  8'h00},
        '{CH_GT,     1'b1, 1'b0, K_IDENT,  8'h00},
        '{CH_GT,     1'b1, 1'b1, K_ARROW,  CH_GT},
        '{CH_GT,     1'b1, 1'b0, K_IDENT,  8'h00},
        '{"_",       1'b0, 1'b0, K_IDENT,  8'h00},
        '{"9",       1'b0, 1'b0, K_IDENT,  8'h00},
        '{".",       1'b0, 1'b0, K_IDENT,  8'h00},
        '{"7",       1'b0, 1'b0, K_IDENT,  8'h00},
        '{".",       1'b0, 1'b0, K_IDENT,  8'h00},
        '{8'h09,     1'b0, 1'b0, K_IDENT,  8'h00},
        '{CH_QUOTE,  1'b1, 1'b0, K_IDENT,  8'h00},
        '{CH_BSLASH, 1'b1, 1'b0, K_IDENT,  8'h00},
        '{CH_N,      1'b0, 1'b0, K_IDENT,  8'h00},
        '{CH_BSLASH, 1'b1, 1'b0, K_IDENT,  8'h00},
        '{"q",       1'b0, 1'b0, K_IDENT,  8'h00},
        '{CH_BSLASH, 1'b1, 1'b0, K_IDENT,  8'h00},
        '{CH_QUOTE,  1'b0, 1'b0, K_IDENT,  8'h00},
        '{CH_QUOTE,  1'b0, 1'b0, K_IDENT,  8'h00},
        '{8'h0A,     1'b1, 1'b0, K_IDENT,  8'h00}
    };

    // Predictor state.
    logic [2:0] scan_state;
    logic [7:0] kw_buf [KW_BUF];
    logic [3:0] word_len;
    bit         text_over;

    t_token_beat fresh [$];
    t_token_beat token_q [$];
    logic [7:0]  text_q [$];

    int err_count;
    int beats_sent;
    int idle_cycles;
    bit calm;

    // Free-running clock.
    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Appends one byte to the text that is still to be sent.
    function automatic void add_text(logic [7:0] c);
        text_q.insert(text_q.size(), c);
    endfunction

    // Appends one beat to the expected token stream.
    function automatic void add_token(t_token_beat beat);
        token_q.insert(token_q.size(), beat);
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void emit(logic tend, logic [5:0] kind, logic [7:0] b);
        t_token_beat beat;
        beat = '{tend, kind, b, 1'b0};
        fresh.insert(fresh.size(), beat);
    endfunction

    // Only the first KW_BUF characters are kept; the length saturates at 15.
    function automatic void keep_char(logic [7:0] c);
        if (word_len < KW_BUF) kw_buf[word_len] = c;
        if (word_len < 4'd15) word_len++;
    endfunction

    function automatic logic [5:0] word_tag();
        logic [5:0] tag;
        bit         hit;
        tag = K_IDENT;
        for (int k = 11; k >= 0; k--) begin
            hit = (kw_text[k].len() == word_len) && (word_len <= KW_BUF);
            for (int i = 0; i < kw_text[k].len(); i++) begin
                if (hit && kw_buf[i] != kw_text[k][i]) hit = 1'b0;
            end
            if (hit) tag = kw_tag[k];
        end
        return tag;
    endfunction

    function automatic logic [5:0] punct_tag(logic [7:0] c);
        for (int i = 0; i < punct_chars.len(); i++) begin
            if (punct_chars[i] == c) return punct_tags[i];
        end
        return K_ERROR;
    endfunction

    // A byte seen between tokens, or right after a token has been closed.
    function automatic void scan_idle(logic [7:0] c, bit fin);
        scan_state = MODE_IDLE;
        if (fin) begin
            text_over = 1'b1;
            emit(1'b1, K_END, 8'h00);
        end else if (c == " " || c == 8'h09 || c == 8'h0D || c == CH_LF) begin
        end else if (c == CH_QUOTE) begin
            scan_state = MODE_STR;
        end else if (c == CH_GT) begin
            scan_state = MODE_GT;
        end else if (is_letter(c) || c == "_") begin
            scan_state = MODE_WORD;
            word_len   = 4'd0;
            keep_char(c);
            emit(1'b0, K_IDENT, c);
        end else if (is_digit(c)) begin
            scan_state = MODE_NUM;
            emit(1'b0, K_NUMBER, c);
        end else begin
            emit(1'b1, punct_tag(c), c);
        end
    endfunction

    // Token beats caused by one accepted text byte; they are left in fresh.
    function automatic void predict_tokens(logic [7:0] c, logic e);
        bit fin;
        fin = e || (c == CH_NUL);
        fresh.delete();
        if (text_over) return;
        case (scan_state)
            MODE_WORD: begin
                if (!fin && (is_letter(c) || is_digit(c) || c == "_")) begin
                    keep_char(c);
                    emit(1'b0, K_IDENT, c);
                end else begin
                    emit(1'b1, word_tag(), 8'h00);
                    scan_idle(c, fin);
                end
            end
            MODE_NUM: begin
                if (!fin && (is_digit(c) || c == ".")) begin
                    emit(1'b0, K_NUMBER, c);
                end else begin
                    emit(1'b1, K_NUMBER, 8'h00);
                    scan_idle(c, fin);
                end
            end
            MODE_STR: begin
                if (fin) begin
                    emit(1'b1, K_STRING, 8'h00);
                    scan_idle(c, fin);
                end else if (c == CH_QUOTE) begin
                    emit(1'b1, K_STRING, 8'h00);
                    scan_state = MODE_IDLE;
                end else if (c == CH_BSLASH) begin
                    scan_state = MODE_ESC;
                end else begin
                    emit(1'b0, K_STRING, c);
                end
            end
            MODE_ESC: begin
                if (fin) begin
                    // The pending backslash is kept before the string closes.
                    emit(1'b0, K_STRING, CH_BSLASH);
                    emit(1'b1, K_STRING, 8'h00);
                    scan_idle(c, fin);
                end else begin
                    if (c == CH_QUOTE || c == CH_BSLASH) begin
                        emit(1'b0, K_STRING, c);
                    end else if (c == CH_N) begin
                        emit(1'b0, K_STRING, CH_LF);
                    end else begin
                        emit(1'b0, K_STRING, CH_BSLASH);
                        emit(1'b0, K_STRING, c);
                    end
                    scan_state = MODE_STR;
                end
            end
            MODE_GT: begin
                if (!fin && c == CH_GT) begin
                    emit(1'b1, K_ARROW, CH_GT);
                    scan_state = MODE_IDLE;
                end else begin
                    emit(1'b1, K_ERROR, CH_GT);
                    scan_idle(c, fin);
                end
            end
            default: scan_idle(c, fin);
        endcase
        if (fresh.size() != 0) fresh[fresh.size() - 1].last = 1'b1;
    endfunction

    function automatic void check_field(string name, int want_v, int got_v);
        if (want_v != got_v) begin
            $error("%s: expected %0d, actual %0d", name, want_v, got_v);
            err_count++;
        end
    endfunction

    // Presents one text beat after a random gap and returns at the edge that takes it.
    task automatic send_beat(input logic [7:0] c, input logic e);
        int gap;
        calm = (beats_sent % 160) >= 120;
        gap  = calm ? 0 : $urandom_range(0, 9);
        @(negedge clk);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= c;
        in_eot   <= e;
        do @(posedge clk); while (!in_ready);
        beats_sent++;
    endtask

    task automatic send_predicted(input logic [7:0] c, input logic e);
        send_beat(c, e);
        predict_tokens(c, e);
        foreach (fresh[i]) add_token(fresh[i]);
    endtask

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) add_text(s[i]);
    endfunction

    function automatic logic [7:0] rand_word_char(bit lead);
        int r;
        r = $urandom_range(0, lead ? 52 : 62);
        if (r < 26) return 8'("A" + r);
        if (r < 52) return 8'("a" + r - 26);
        if (r == 52) return "_";
        return 8'("0" + r - 53);
    endfunction

    // Random source text: mostly well-formed tokens, some spoiled ones and noise.
    task automatic build_text(input int goal);
        int         pick;
        int         n;
        int         pos;
        bit         sep;
        string      w;
        logic [7:0] c;
        while (text_q.size() < goal) begin
            pick = $urandom_range(0, 99);
            sep  = 1'b0;
            if (pick < 20) begin
                // Keyword, now and then with a flipped case, an extra or a missing char.
                w = kw_text[$urandom_range(0, 11)];
                case ($urandom_range(0, 7))
                    0: begin
                        pos = $urandom_range(0, w.len() - 1);
                        w.putc(pos, w[pos] ^ 8'h20);
                    end
                    1: w = {w, "x"};
                    2: w = w.substr(0, w.len() - 2);
                    default: ;
                endcase
                push_text(w);
                sep = 1'b1;
            end else if (pick < 35) begin
                // Identifier; a fifth are long enough to fill or overflow the keyword buffer.
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
                add_text(rand_word_char(1'b1));
                for (int i = 1; i < n; i++) add_text(rand_word_char(1'b0));
                sep = 1'b1;
            end else if (pick < 45) begin
                add_text(8'("0" + $urandom_range(0, 9)));
                n = $urandom_range(0, 5);
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(0, 4) == 0) add_text(".");
                    else add_text(8'("0" + $urandom_range(0, 9)));
                end
                sep = 1'b1;
            end else if (pick < 60) begin
                // Quoted string with random content and escapes; rarely left open.
                add_text(CH_QUOTE);
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(0, 3) == 0) begin
                        add_text(CH_BSLASH);
                        case ($urandom_range(0, 3))
                            0: add_text(CH_QUOTE);
                            1: add_text(CH_BSLASH);
                            2: add_text(CH_N);
                            default: add_text(8'($urandom_range(1, 255)));
                        endcase
                    end else begin
                        do c = 8'($urandom_range(1, 255));
                        while (c == CH_QUOTE || c == CH_BSLASH);
                        add_text(c);
                    end
                end
                if ($urandom_range(0, 11) != 0) add_text(CH_QUOTE);
            end else if (pick < 75) begin
                add_text(punct_chars[$urandom_range(0, punct_chars.len() - 1)]);
            end else if (pick < 83) begin
                add_text(CH_GT);
                if ($urandom_range(0, 1) != 0) add_text(CH_GT);
            end else if (pick < 90) begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++) add_text(blanks[$urandom_range(0, 3)]);
            end else begin
                add_text(8'($urandom_range(1, 255)));
            end
            if (sep && $urandom_range(0, 4) < 3) add_text(blanks[$urandom_range(0, 3)]);
        end
    endtask

    // Receiver: a random stall before each beat it takes.
    initial begin : sink
        int stall;
        forever begin
            @(negedge clk);
            stall = calm ? 0 : $urandom_range(0, 9);
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Each delivered beat must match the oldest expected token beat.
    always @(posedge clk) begin : check_tokens
        t_token_beat want;
        if (rst_n && out_valid && out_ready) begin
            if (token_q.size() == 0) begin
                $error("unexpected token beat: end %0d kind %0d byte %0d last %0d",
                       tok_end, tok_kind, tok_byte, tok_last);
                err_count++;
            end else begin
                want = token_q.pop_front();
                check_field("token_end", want.tend, tok_end);
                check_field("token_kind", want.kind, tok_kind);
                check_field("byte_out", want.byt, tok_byte);
                check_field("last_of_run", want.last, tok_last);
            end
        end
    end

    // Watchdog: too long without any beat on either side ends the run.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus: reset, directed table, random text, then one way of ending the text.
    initial begin : stimulus
        string tail_txt [6];
        int    style;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_byte     = 8'h00;
        in_eot      = 1'b0;
        out_ready   = 1'b0;
        err_count   = 0;
        beats_sent  = 0;
        idle_cycles = 0;
        calm        = 1'b0;
        scan_state  = MODE_IDLE;
        word_len    = 4'd0;
        text_over   = 1'b0;
        foreach (kw_buf[i]) kw_buf[i] = 8'h00;
        tail_txt = '{" ", "ab", "42", "\"s", "\"s\\", ">"};

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_tbl[i]) begin
            send_beat(dir_tbl[i].ch, 1'b0);
            predict_tokens(dir_tbl[i].ch, 1'b0);
            if (!dir_tbl[i].typed) begin
                foreach (fresh[j]) add_token(fresh[j]);
            end else if (dir_tbl[i].has_res) begin
                add_token(t_token_beat'{1'b1, dir_tbl[i].kind, dir_tbl[i].byt, 1'b1});
            end
        end

        build_text(TEXT_BEATS);
        foreach (text_q[i]) send_predicted(text_q[i], 1'b0);

        // The text ends once per run, from a random scanner mode, by NUL or by the flag.
        style = $urandom_range(0, 5);
        for (int i = 0; i < tail_txt[style].len(); i++) send_predicted(tail_txt[style][i], 1'b0);
        if ($urandom_range(0, 1) != 0) send_predicted(CH_NUL, 1'b0);
        else send_predicted(8'($urandom_range(0, 255)), 1'b1);

        // Beats after the end of text are taken but give nothing.
        for (int i = 0; i < 4; i++) send_predicted(8'($urandom_range(0, 255)), i[0]);
        @(negedge clk);
        in_valid <= 1'b0;

        while (token_q.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
